@@ rtl/ppo_pkg.sv @@
// Package for the passepartout overlay: payload types, edge type and constants.
`timescale 1ns / 1ps
package ppo_pkg;

	// Fixed widths of the configuration registers
	localparam int DIM_W    = 12;
	localparam int ASPECT_W = 16;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 2;

	// Edge positions are signed: a far edge may fall below zero on a tiny frame
	localparam int EDGE_W = DIM_W + 2;

	// Minimum distance of the inner rectangle from the frame border
	localparam int BORDER_GAP = 2;

	// Aspect ratio 1.0 in Q8.8
	localparam logic [ASPECT_W-1:0] ASPECT_ONE = 16'd256;

	// Register indices
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_ASPECT       = 2'd2;

	// Reset values of the registers
	localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 12'd128;
	localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 12'd128;
	localparam logic [ASPECT_W-1:0] RST_ASPECT       = 16'd256;

	// Quotient bits produced by the edge divider, one per cycle
	localparam int DIV_STEPS = DIM_W;

	// Dimmed alpha offset and opaque alpha
	localparam logic [7:0] DIM_ALPHA_OFS = 8'd96;
	localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

	typedef struct packed {
		logic [7:0] in_byte0;
		logic [7:0] in_byte1;
		logic [7:0] in_byte2;
		logic [7:0] in_byte3;
	} pix_t;

	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_byte3;
		logic       frame_done;
	} res_t;

	typedef struct packed {
		logic signed [EDGE_W-1:0] left;
		logic signed [EDGE_W-1:0] right;
		logic signed [EDGE_W-1:0] bottom;
		logic signed [EDGE_W-1:0] top;
	} edges_t;

endpackage

@@ rtl/ppo_edge_calc.sv @@
// Multi-cycle computation of the inner rectangle edges from width, height and aspect.
`timescale 1ns / 1ps
module ppo_edge_calc (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [ppo_pkg::DIM_W-1:0]       width,
	input  logic [ppo_pkg::DIM_W-1:0]       height,
	input  logic [ppo_pkg::ASPECT_W-1:0]    aspect,
	output logic                            busy,
	output ppo_pkg::edges_t                 edges
);
	import ppo_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MUL   = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_APPLY = 2'd3;

	localparam int PROD_W = DIM_W + ASPECT_W;
	localparam int DEN_W  = ASPECT_W + 1;
	localparam int CNT_W  = $clog2(DIV_STEPS);
	localparam int LO_SH  = 9;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DEN_W-1:0]      rem_q;
	logic [DIV_STEPS-1:0]  low_q;
	logic [DIV_STEPS-1:0]  quo_q;
	edges_t                edges_q;

	logic                  wide;
	logic                  tall;
	logic [DIM_W-1:0]      mul_a;
	logic [ASPECT_W-1:0]   mul_b;
	logic [PROD_W-1:0]     product;
	logic [DEN_W-1:0]      den;
	logic [DEN_W:0]        trial;
	logic                  fits;
	logic [DIM_W:0]        cand;
	logic [DIM_W-1:0]      half_w;
	logic [DIM_W-1:0]      half_h;
	logic [DIM_W:0]        near_w;
	logic [DIM_W:0]        near_h;
	logic signed [EDGE_W-1:0] w_s;
	logic signed [EDGE_W-1:0] h_s;
	logic signed [EDGE_W-1:0] gap_s;
	edges_t                edges_d;

	assign wide = aspect < ASPECT_ONE;
	assign tall = aspect > ASPECT_ONE;

	// One shared multiplier: width by (1.0 - aspect) or height by (aspect - 1.0)
	assign mul_a   = wide ? width : height;
	assign mul_b   = wide ? ASPECT_W'(ASPECT_ONE - aspect) : ASPECT_W'(aspect - ASPECT_ONE);
	assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Restoring division by twice the aspect; the quotient stays below height / 2
	assign den   = {aspect, 1'b0};
	assign trial = {rem_q, low_q[DIV_STEPS-1]};
	assign fits  = trial >= {1'b0, den};

	assign w_s   = $signed({2'b00, width});
	assign h_s   = $signed({2'b00, height});
	assign gap_s = EDGE_W'(BORDER_GAP);

	assign cand   = {1'b0, quo_q} + (DIM_W + 1)'(BORDER_GAP);
	assign half_w = width >> 1;
	assign half_h = height >> 1;
	assign near_w = (cand > {1'b0, half_w}) ? {1'b0, half_w} : cand;
	assign near_h = (cand > {1'b0, half_h}) ? {1'b0, half_h} : cand;

	always_comb begin
		edges_d.left   = gap_s;
		edges_d.bottom = gap_s;
		edges_d.right  = w_s - gap_s;
		edges_d.top    = h_s - gap_s;
		if (wide) begin
			edges_d.left  = $signed({1'b0, near_w});
			edges_d.right = w_s - $signed({1'b0, near_w});
		end else if (tall) begin
			edges_d.bottom = $signed({1'b0, near_h});
			edges_d.top    = h_s - $signed({1'b0, near_h});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			edges_q.left   <= EDGE_W'(BORDER_GAP);
			edges_q.bottom <= EDGE_W'(BORDER_GAP);
			edges_q.right  <= EDGE_W'({2'b00, RST_FRAME_WIDTH}) - EDGE_W'(BORDER_GAP);
			edges_q.top    <= EDGE_W'({2'b00, RST_FRAME_HEIGHT}) - EDGE_W'(BORDER_GAP);
		end else if (start) begin
			// A fresh write restarts the computation with the latest registers
			state_q <= ST_MUL;
		end else begin
			case (state_q)
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= tall ? ST_DIV : ST_APPLY;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					edges_q <= edges_d;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			rem_q <= {1'b0, product[PROD_W-1:DIV_STEPS]};
			low_q <= product[DIV_STEPS-1:0];
			quo_q <= product[LO_SH+DIV_STEPS-1:LO_SH];
		end else if (state_q == ST_DIV) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
			low_q <= {low_q[DIV_STEPS-2:0], 1'b0};
			quo_q <= {quo_q[DIV_STEPS-2:0], fits};
		end
	end

	assign busy  = state_q != ST_IDLE;
	assign edges = edges_q;

endmodule

@@ rtl/passepartout_overlay.sv @@
// Passepartout overlay top level: frame counters, pixel shading and output buffer.
//
// Pixels enter on the pixel channel (pixel_valid, pixel_stall, pixel) in raster
// order and leave on the result channel (result_valid, result_stall, result),
// one result beat per pixel beat, with frame_done set on the last pixel.
// A pixel beat is shaded in the cycle it is accepted and is held in the output
// register, or the skid register under a stall; one pixel per clock is sustained
// while the receiver keeps result_stall low and no edge computation is running.
// The output register is backed by a skid register, so a stall on the result
// side stalls the pixel side once a beat waits in skid, and no beat is lost.
// A configuration write (cfg_we, cfg_index, cfg_data) to one of the three
// registers recomputes the inner rectangle: a multiply step, a restoring division
// when the aspect is above 1.0, and a step to load the edges. The pixel channel
// is stalled during any write and while the edge computation is busy.
// Reset clears the counters, empties the output stage and loads a 128 by 128
// frame with aspect 1.0 and its edges.
`timescale 1ns / 1ps
module passepartout_overlay #(
	parameter int DIM_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ppo_pkg::IDX_W-1:0]     cfg_index,
	input  logic [ppo_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          pixel_valid,
	output logic                          pixel_stall,
	input  ppo_pkg::pix_t                 pixel,
	output logic                          result_valid,
	input  logic                          result_stall,
	output ppo_pkg::res_t                 result
);
	import ppo_pkg::*;

	localparam int CW = (DIM_BITS + 1 > DIM_W) ? DIM_BITS + 1 : DIM_W;
	localparam int SW = ((DIM_BITS + 1 > EDGE_W) ? DIM_BITS + 1 : EDGE_W) + 1;

	logic [DIM_W-1:0]     width_q;
	logic [DIM_W-1:0]     height_q;
	logic [ASPECT_W-1:0]  aspect_q;
	logic [DIM_BITS-1:0]  col_q;
	logic [DIM_BITS-1:0]  row_q;
	res_t                 out_q;
	res_t                 skid_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;

	logic                 cfg_hit;
	logic                 calc_busy;
	edges_t               edges;
	logic                 take;
	logic                 out_free;
	logic [DIM_BITS:0]    col_inc;
	logic [DIM_BITS:0]    row_inc;
	logic                 row_end;
	logic                 frame_end;
	logic signed [SW-1:0] x;
	logic signed [SW-1:0] y;
	logic signed [SW-1:0] el;
	logic signed [SW-1:0] er;
	logic signed [SW-1:0] eb;
	logic signed [SW-1:0] et;
	logic                 interior;
	logic                 vert;
	logic                 horz;
	res_t                 shaded;

	assign cfg_hit = cfg_we && (cfg_index == REG_FRAME_WIDTH ||
		cfg_index == REG_FRAME_HEIGHT || cfg_index == REG_ASPECT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_FRAME_WIDTH;
			height_q <= RST_FRAME_HEIGHT;
			aspect_q <= RST_ASPECT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_ASPECT:       aspect_q <= cfg_data[ASPECT_W-1:0];
				default: ;
			endcase
		end
	end

	ppo_edge_calc u_edge_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_hit),
		.width  (width_q),
		.height (height_q),
		.aspect (aspect_q),
		.busy   (calc_busy),
		.edges  (edges)
	);

	assign pixel_stall = skid_valid_q || calc_busy || cfg_we;
	assign take        = pixel_valid && !pixel_stall;

	// Position bookkeeping; a count at or beyond the size ends the row or frame
	assign col_inc   = {1'b0, col_q} + 1'b1;
	assign row_inc   = {1'b0, row_q} + 1'b1;
	assign row_end   = CW'(col_inc) >= CW'(width_q);
	assign frame_end = row_end && (CW'(row_inc) >= CW'(height_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_inc[DIM_BITS-1:0];
			end else begin
				col_q <= col_inc[DIM_BITS-1:0];
			end
		end
	end

	assign x  = $signed({{(SW - DIM_BITS){1'b0}}, col_q});
	assign y  = $signed({{(SW - DIM_BITS){1'b0}}, row_q});
	assign el = {{(SW - EDGE_W){edges.left[EDGE_W-1]}}, edges.left};
	assign er = {{(SW - EDGE_W){edges.right[EDGE_W-1]}}, edges.right};
	assign eb = {{(SW - EDGE_W){edges.bottom[EDGE_W-1]}}, edges.bottom};
	assign et = {{(SW - EDGE_W){edges.top[EDGE_W-1]}}, edges.top};

	assign interior = x > el && x < er && y > eb && y < et;
	assign vert     = (x == el || x == er) && y >= eb && y <= et;
	assign horz     = (y == eb || y == et) && x >= el && x <= er;

	always_comb begin
		shaded.out_byte0  = pixel.in_byte0;
		shaded.out_byte1  = pixel.in_byte1;
		shaded.out_byte2  = pixel.in_byte2;
		shaded.out_byte3  = pixel.in_byte3;
		shaded.frame_done = frame_end;
		if (interior) begin
			shaded.out_byte0 = pixel.in_byte0;
		end else if (vert || horz) begin
			// The vertical edges take precedence at the corners, dashed by row
			if (vert ? y[0] : x[0]) begin
				shaded.out_byte0 = '0;
				shaded.out_byte1 = '0;
				shaded.out_byte2 = '0;
				shaded.out_byte3 = ALPHA_OPAQUE;
			end
		end else begin
			shaded.out_byte0 = pixel.in_byte0 >> 1;
			shaded.out_byte1 = pixel.in_byte1 >> 1;
			shaded.out_byte2 = pixel.in_byte2 >> 1;
			shaded.out_byte3 = (pixel.in_byte3 >> 1) + DIM_ALPHA_OFS;
		end
	end

	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= take;
			end
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (take) begin
				out_q <= shaded;
			end
		end else if (take) begin
			skid_q <= shaded;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
